FILE: src/spq_pkg.sv
// shared constants, types and state codes of the sorted priority queue
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PRIO_WIDTH = 8;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int IN_TDATA_W  = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  typedef struct packed {
    logic [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0] data;
  } entry_t;

  typedef struct packed {
    logic                  func;
    logic [DATA_WIDTH-1:0] data;
    logic [PRIO_WIDTH-1:0] prio;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic                  ok;
    logic                  full;
    logic                  empty;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_PULL,
    ST_DONE
  } state_t;

endpackage

FILE: src/sorted_priority_queue.sv
// sorted priority queue top level: stream ports and output register
// A bounded priority queue of CAPACITY entries, ordered by descending priority with
// equal priorities leaving in arrival order. Each input word (tuser[0] = 0 push,
// 1 pull) yields exactly one result word. Entries live in one single-port-read
// ring memory, so the head pull is a single read. A push into a non-empty queue
// walks back from the tail one memory read and write per cycle, moving each entry
// of lower priority up a slot. A push into an empty queue writes at once, and
// pushes into a full queue and pulls from an empty queue go straight to their
// result. A new word is accepted only when the previous one has finished; a
// result waiting in the output register does not hold up the next accept. No
// clearing pass follows reset.
module sorted_priority_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // data_in [31:0], priority_req [39:32]
  input  logic [spq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // data_out [31:0]
  output logic [spq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // ok [0], full_res [1], empty_res [2]
  output logic [spq_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  spq_pkg::req_t req;
  spq_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic          out_valid_r, out_valid_nxt;
  spq_pkg::res_t out_r, out_nxt;

  assign req.func = in_tuser;
  assign req.data = in_tdata[spq_pkg::DATA_WIDTH-1:0];
  assign req.prio = in_tdata[spq_pkg::DATA_WIDTH +: spq_pkg::PRIO_WIDTH];

  spq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees up as the current word leaves
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = spq_pkg::OUT_TDATA_W'(out_r.data);
  assign out_tuser  = {out_r.empty, out_r.full, out_r.ok};

endmodule

FILE: src/spq_core.sv
// entry memory kept as a sorted ring and the sequencer that inserts and removes entries
module spq_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output spq_pkg::res_t res
);

  localparam int IDX_W = spq_pkg::IDX_W;
  localparam int CNT_W = spq_pkg::CNT_W;

  spq_pkg::entry_t mem [spq_pkg::CAPACITY];
  spq_pkg::entry_t rd_q;

  spq_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  spq_pkg::entry_t  new_r, new_nxt;
  spq_pkg::res_t    res_r, res_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  spq_pkg::entry_t  mem_wd;
  logic [IDX_W-1:0] mem_ra;

  // ring address of a logical slot, slot 0 being the head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W+1)'(spq_pkg::CAPACITY)) begin
      sum = sum - (IDX_W+1)'(spq_pkg::CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_wa    = phys(head_r, pos_r);
    mem_wd    = new_r;
    mem_ra    = phys(head_r, pos_r - IDX_W'(2));
    req_ready = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      spq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          new_nxt.data = req.data;
          new_nxt.prio = req.prio;
          res_nxt.data = '0;
          if (req.func == spq_pkg::FUNC_PUSH) begin
            if (count_r == CNT_W'(spq_pkg::CAPACITY)) begin
              res_nxt.ok    = 1'b0;
              res_nxt.full  = 1'b1;
              res_nxt.empty = 1'b0;
              state_nxt     = spq_pkg::ST_DONE;
            end else if (count_r == '0) begin
              mem_we        = 1'b1;
              mem_wa        = head_r;
              mem_wd.data   = req.data;
              mem_wd.prio   = req.prio;
              count_nxt     = CNT_W'(1);
              res_nxt.ok    = 1'b1;
              res_nxt.full  = 1'b0;
              res_nxt.empty = 1'b0;
              state_nxt     = spq_pkg::ST_DONE;
            end else begin
              // walk back from the tail, moving lower-priority entries up one slot
              pos_nxt   = count_r[IDX_W-1:0];
              mem_ra    = phys(head_r, count_r[IDX_W-1:0] - IDX_W'(1));
              state_nxt = spq_pkg::ST_SHIFT;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.ok    = 1'b0;
              res_nxt.full  = 1'b0;
              res_nxt.empty = 1'b1;
              state_nxt     = spq_pkg::ST_DONE;
            end else begin
              mem_ra    = head_r;
              state_nxt = spq_pkg::ST_PULL;
            end
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        // rd_q holds logical slot pos_r - 1
        mem_we = 1'b1;
        if (rd_q.prio < new_r.prio) begin
          mem_wd = rd_q;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = spq_pkg::ST_PLACE;
          end
        end else begin
          count_nxt     = count_r + CNT_W'(1);
          res_nxt.ok    = 1'b1;
          res_nxt.full  = 1'b0;
          res_nxt.empty = 1'b0;
          state_nxt     = spq_pkg::ST_DONE;
        end
      end
      spq_pkg::ST_PLACE: begin
        mem_we        = 1'b1;
        count_nxt     = count_r + CNT_W'(1);
        res_nxt.ok    = 1'b1;
        res_nxt.full  = 1'b0;
        res_nxt.empty = 1'b0;
        state_nxt     = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_PULL: begin
        head_nxt      = phys(head_r, IDX_W'(1));
        count_nxt     = count_r - CNT_W'(1);
        res_nxt.data  = rd_q.data;
        res_nxt.ok    = 1'b1;
        res_nxt.full  = 1'b0;
        res_nxt.empty = (count_r == CNT_W'(1));
        state_nxt     = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

FILE: tb/tb_sorted_priority_queue.sv
// self-checking testbench for the sorted priority queue with a shadow queue model
module tb_sorted_priority_queue;

  typedef struct {
    logic                           func;
    logic [spq_pkg::DATA_WIDTH-1:0] data;
    logic [spq_pkg::PRIO_WIDTH-1:0] prio;
    bit                             drain;  // wait for all results before offering this word
  } op_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [spq_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [spq_pkg::OUT_TUSER_W-1:0] out_tuser;

  op_t           pending_ops[$];
  spq_pkg::res_t expected_res[$];

  // shadow copy of the queue contents, slot 0 is the head
  logic [spq_pkg::DATA_WIDTH-1:0] shadow_data[spq_pkg::CAPACITY];
  logic [spq_pkg::PRIO_WIDTH-1:0] shadow_prio[spq_pkg::CAPACITY];
  int                             shadow_count;

  int  n_items;
  int  in_count;
  int  out_count;
  int  n_errors;
  int  n_push_ok, n_push_full, n_pull_ok, n_pull_empty, max_fill;
  bit  in_fire;
  bit  rx_hold;
  int  tx_idle_pct, rx_idle_pct;

  sorted_priority_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // apply one operation to the shadow queue and work out its result word
  task automatic queue_apply(input logic func, input logic [spq_pkg::DATA_WIDTH-1:0] data,
                             input logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                             output spq_pkg::res_t r);
    int pos;
    r = '0;
    if (func == spq_pkg::FUNC_PUSH) begin
      if (shadow_count >= spq_pkg::CAPACITY) begin
        r.full = 1'b1;
        n_push_full++;
      end else begin
        pos = 0;
        while (pos < shadow_count && prio <= shadow_prio[pos]) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = data;
        shadow_prio[pos] = prio;
        shadow_count++;
        r.ok = 1'b1;
        n_push_ok++;
        if (shadow_count > max_fill) max_fill = shadow_count;
      end
    end else begin
      if (shadow_count == 0) begin
        n_pull_empty++;
      end else begin
        r.data = shadow_data[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_data[i-1] = shadow_data[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
        r.ok = 1'b1;
        n_pull_ok++;
      end
    end
    r.empty = (shadow_count == 0);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("[%0t] mismatch on result %0d: %s got %0h expected %0h",
             $time, out_count, what, got, want);
  endtask

  function automatic logic [spq_pkg::PRIO_WIDTH-1:0] pick_prio();
    case ($urandom_range(3))
      0:       pick_prio = $urandom_range(1) ? {spq_pkg::PRIO_WIDTH{1'b1}} : '0;
      1:       pick_prio = spq_pkg::PRIO_WIDTH'($urandom_range(3));
      default: pick_prio = spq_pkg::PRIO_WIDTH'($urandom);
    endcase
  endfunction

  function automatic op_t make_op(input logic func,
                                  input logic [spq_pkg::DATA_WIDTH-1:0] data,
                                  input logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                                  input bit drain);
    op_t o;
    o.func  = func;
    o.data  = data;
    o.prio  = prio;
    o.drain = drain;
    return o;
  endfunction

  // stimulus: directed words first, then random runs with a varying push mix
  initial begin
    int seg_len, push_pct, n_rand;
    pending_ops.push_back(make_op(spq_pkg::FUNC_PULL, '1, '1, 1'b0));  // pull while empty
    pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, '0, '0, 1'b0));
    pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, '1, '1, 1'b0));
    // tie at the top
    pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, 32'h5555_aaaa, '1, 1'b0));
    // tie at the bottom
    pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, 32'h0000_0001, '0, 1'b0));
    pending_ops.push_back(make_op(spq_pkg::FUNC_PULL, '0, '0, 1'b0));
    for (int i = 0; i < 13; i++)
      pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, spq_pkg::DATA_WIDTH'($urandom),
                                    spq_pkg::PRIO_WIDTH'(i * 19), 1'b0));
    // push when full
    pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, 32'hdead_beef, 8'h80, 1'b0));
    pending_ops.push_back(make_op(spq_pkg::FUNC_PULL, '0, '0, 1'b0));
    pending_ops.push_back(make_op(spq_pkg::FUNC_PUSH, 32'hcafe_f00d, 8'h7f, 1'b0));

    n_rand = 0;
    while (n_rand < 1600) begin
      seg_len = $urandom_range(60, 10);
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 50;
        2:       push_pct = 75;
        default: push_pct = 95;
      endcase
      for (int i = 0; i < seg_len; i++) begin
        pending_ops.push_back(make_op(($urandom_range(99) < push_pct) ?
                                        spq_pkg::FUNC_PUSH : spq_pkg::FUNC_PULL,
                                      spq_pkg::DATA_WIDTH'($urandom), pick_prio(),
                                      (i == 0) && ($urandom_range(3) == 0)));
      end
      n_rand += seg_len;
    end
    n_items = pending_ops.size();
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
  end

  // idling mix by progress: none, sender, receiver, both
  always @(negedge clk) begin
    case ((n_items == 0) ? 0 : (in_count * 4) / n_items)
      0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      1:       begin tx_idle_pct = 61; rx_idle_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_idle_pct = 61; end
      default: begin tx_idle_pct = 18; rx_idle_pct = 18; end
    endcase
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_ops.size() > 0 && !(pending_ops[0].drain && expected_res.size() > 0)
          && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_ops[0].func;
        in_tdata  <= spq_pkg::IN_TDATA_W'({pending_ops[0].prio, pending_ops[0].data});
        void'(pending_ops.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side ready
  always @(negedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    rx_hold = 1'b0;
    wait (rst_n && in_count >= 300);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    spq_pkg::res_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        queue_apply(in_tuser, in_tdata[spq_pkg::DATA_WIDTH-1:0],
                    in_tdata[spq_pkg::DATA_WIDTH+spq_pkg::PRIO_WIDTH-1:spq_pkg::DATA_WIDTH],
                    want);
        expected_res.push_back(want);
        in_count++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected word", 64'({out_tuser, out_tdata}), '0);
        end else begin
          want = expected_res.pop_front();
          if (out_tdata[spq_pkg::DATA_WIDTH-1:0] !== want.data)
            report_mismatch("data_out", 64'(out_tdata), 64'(want.data));
          if (out_tuser[0] !== want.ok)
            report_mismatch("ok", 64'(out_tuser[0]), 64'(want.ok));
          if (out_tuser[1] !== want.full)
            report_mismatch("full_res", 64'(out_tuser[1]), 64'(want.full));
          if (out_tuser[2] !== want.empty)
            report_mismatch("empty_res", 64'(out_tuser[2]), 64'(want.empty));
        end
        out_count++;
      end
    end
  end

  initial begin
    wait (n_items > 0 && in_count == n_items && expected_res.size() == 0);
    repeat (40) @(posedge clk);
    if (expected_res.size() != 0) begin
      n_errors++;
      $display("%0d results never arrived", expected_res.size());
    end
    $display("covered %0d words: %0d pushes stored, %0d rejected full, %0d pulls served",
             in_count, n_push_ok, n_push_full, n_pull_ok);
    $display("%0d pulls on empty, deepest fill %0d of %0d, %0d mismatches",
             n_pull_empty, max_fill, spq_pkg::CAPACITY, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d of %0d words accepted", in_count, n_items);
    $display("simulation failed");
    $finish;
  end

endmodule
